// ----- design/twtq_pkg.sv -----
// Shared command codes and result flag type for the timer heap queue.
`default_nettype none

package twtq_pkg;

    localparam int CMD_W = 2;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_PUSH = 2'd0;
    localparam cmd_t CMD_FIRE = 2'd1;
    localparam cmd_t CMD_POP  = 2'd2;

    typedef struct packed {
        logic accepted;
        logic overflow;
        logic fired;
    } res_flags_t;

endpackage

`default_nettype wire

// ----- design/twtq_mem.sv -----
// Heap entry storage: one write port, one read port with registered read data.
`default_nettype none

module twtq_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 24
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/twtq_cmp.sv -----
// Shared wrapped-distance comparator: (a - a_base) < (b - b_base), modulo 2^TIME_BITS.
`default_nettype none

module twtq_cmp #(
    parameter int TIME_BITS = 16
) (
    input  wire logic [TIME_BITS-1:0] a,
    input  wire logic [TIME_BITS-1:0] a_base,
    input  wire logic [TIME_BITS-1:0] b,
    input  wire logic [TIME_BITS-1:0] b_base,
    output logic                      lt
);

    logic [TIME_BITS-1:0] dist_a;
    logic [TIME_BITS-1:0] dist_b;

    assign dist_a = a - a_base;
    assign dist_b = b - b_base;
    assign lt     = (dist_a < dist_b);

endmodule

`default_nettype wire

// ----- design/wrapping_time_priority_queue_top.sv -----
// Timer event queue kept as a binary min-heap in a single-port-read RAM.
`default_nettype none

// Timer queue as a binary min-heap: slot 0 is the root, slot 1 its only child,
// slot i (i >= 1) has children 2i and 2i+1. Commands: push (due = time_now +
// delay), fire (remove root if due) and pop (remove root). One command is in
// work at a time; cmd_ready is low from acceptance until the result beat is
// loaded into the output register. Each level a push climbs costs one RAM read
// and one pass through the shared wrapped-distance comparator; each level a
// removal sinks costs two reads and two passes (one of each at slot 1). A result
// beat may wait in the output register while the next command is accepted and
// worked on.
module wrapping_time_priority_queue_top
    import twtq_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int TIME_BITS   = 16,
    parameter int HANDLE_BITS = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cmd_valid,
    output logic                                  cmd_ready,
    input  wire logic [CMD_W-1:0]                 command,
    input  wire logic [TIME_BITS-1:0]             time_now,
    input  wire logic [TIME_BITS-1:0]             delay,
    input  wire logic [HANDLE_BITS-1:0]           handle,
    output logic                                  res_valid,
    input  wire logic                             res_ready,
    output logic                                  accepted,
    output logic                                  overflow,
    output logic                                  fired,
    output logic [HANDLE_BITS-1:0]                fired_handle,
    output logic [TIME_BITS-1:0]                  fired_time,
    output logic [$clog2(CAPACITY+1)-1:0]         entries
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = CNT_W + 1;
    localparam int DATA_W = TIME_BITS + HANDLE_BITS;

    localparam logic [CNT_W-1:0]     CAP_CNT   = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0]     CNT_ONE   = CNT_W'(1);
    localparam logic [IDX_W-1:0]     IDX_ONE   = IDX_W'(1);
    localparam logic [TIME_BITS-1:0] DUE_LIMIT = {1'b0, {(TIME_BITS-1){1'b1}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_CMP,
        S_PUSH_WR,
        S_ROOT,
        S_LAST,
        S_RD_A,
        S_RD_B,
        S_SINK,
        S_FIN,
        S_OUT
    } state_t;

    state_t                   state_reg,     state_next;
    cmd_t                     cmd_reg,       cmd_next;
    logic [TIME_BITS-1:0]     now_reg,       now_next;
    logic [TIME_BITS-1:0]     delay_reg,     delay_next;
    logic [HANDLE_BITS-1:0]   hnd_reg,       hnd_next;
    logic [CNT_W-1:0]         count_reg,     count_next;
    logic [IDX_W-1:0]         idx_reg,       idx_next;
    logic [CNT_W-1:0]         last_idx_reg,  last_idx_next;
    logic [DATA_W-1:0]        root_reg,      root_next;
    logic [DATA_W-1:0]        last_reg,      last_next;
    logic [DATA_W-1:0]        cand_reg,      cand_next;
    res_flags_t               flags_reg,     flags_next;
    logic                     res_valid_reg, res_valid_next;
    res_flags_t               out_flags_reg, out_flags_next;
    logic [HANDLE_BITS-1:0]   out_hnd_reg,   out_hnd_next;
    logic [TIME_BITS-1:0]     out_time_reg,  out_time_next;
    logic [CNT_W-1:0]         out_cnt_reg,   out_cnt_next;

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [DATA_W-1:0]        mem_wdata;
    logic [ADDR_W-1:0]        mem_raddr;
    logic [DATA_W-1:0]        mem_rdata;

    logic [TIME_BITS-1:0]     cmp_a;
    logic [TIME_BITS-1:0]     cmp_a_base;
    logic [TIME_BITS-1:0]     cmp_b;
    logic [TIME_BITS-1:0]     cmp_b_base;
    logic                     cmp_lt;

    logic [IDX_W-1:0]         idx_half;
    logic [IDX_W-1:0]         idx_quarter;
    logic [IDX_W-1:0]         idx_inc;
    logic [IDX_W-1:0]         idx_dbl;
    logic [CNT_W-1:0]         cnt_inc;
    logic [CNT_W-1:0]         cnt_dec;
    logic [CNT_W-1:0]         cnt_half;
    logic [DATA_W-1:0]        new_entry;
    logic [TIME_BITS-1:0]     rd_when;
    logic [TIME_BITS-1:0]     root_when;

    twtq_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    twtq_cmp #(
        .TIME_BITS (TIME_BITS)
    ) u_cmp (
        .a      (cmp_a),
        .a_base (cmp_a_base),
        .b      (cmp_b),
        .b_base (cmp_b_base),
        .lt     (cmp_lt)
    );

    assign idx_half    = idx_reg >> 1;
    assign idx_quarter = idx_reg >> 2;
    assign idx_inc     = idx_reg + IDX_ONE;
    assign idx_dbl     = {idx_reg[IDX_W-2:0], 1'b0};
    assign cnt_inc     = count_reg + CNT_ONE;
    assign cnt_dec     = count_reg - CNT_ONE;
    assign cnt_half    = count_reg >> 1;
    assign new_entry   = {now_reg + delay_reg, hnd_reg};
    assign rd_when     = mem_rdata[DATA_W-1:HANDLE_BITS];
    assign root_when   = root_reg[DATA_W-1:HANDLE_BITS];

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        now_next       = now_reg;
        delay_next     = delay_reg;
        hnd_next       = hnd_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        root_next      = root_reg;
        last_next      = last_reg;
        cand_next      = cand_reg;
        flags_next     = flags_reg;
        res_valid_next = res_valid_reg && !res_ready;
        out_flags_next = out_flags_reg;
        out_hnd_next   = out_hnd_reg;
        out_time_next  = out_time_reg;
        out_cnt_next   = out_cnt_reg;

        mem_we     = 1'b0;
        mem_waddr  = idx_reg[ADDR_W-1:0];
        mem_wdata  = new_entry;
        mem_raddr  = '0;

        cmp_a      = '0;
        cmp_a_base = '0;
        cmp_b      = '0;
        cmp_b_base = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = command;
                    now_next   = time_now;
                    delay_next = delay;
                    hnd_next   = handle;
                    flags_next = '0;
                    case (command)
                        CMD_PUSH:
                        begin
                            if (count_reg == CAP_CNT)
                            begin
                                flags_next.overflow = 1'b1;
                                state_next          = S_OUT;
                            end
                            else if (count_reg == '0)
                            begin
                                // Empty heap: the new entry becomes the root.
                                mem_we              = 1'b1;
                                mem_waddr           = '0;
                                mem_wdata           = {time_now + delay, handle};
                                count_next          = cnt_inc;
                                flags_next.accepted = 1'b1;
                                state_next          = S_OUT;
                            end
                            else
                            begin
                                idx_next   = {1'b0, count_reg};
                                mem_raddr  = cnt_half[ADDR_W-1:0];
                                state_next = S_PUSH_CMP;
                            end
                        end
                        CMD_FIRE, CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = S_OUT;
                            end
                            else
                            begin
                                mem_raddr  = '0;
                                state_next = S_ROOT;
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_PUSH_CMP:
            begin
                // Parent in mem_rdata; move it down while the new entry is due earlier.
                cmp_a      = delay_reg;
                cmp_b      = rd_when;
                cmp_b_base = now_reg;
                mem_we     = 1'b1;
                if (cmp_lt)
                begin
                    mem_wdata = mem_rdata;
                    idx_next  = idx_half;
                    if (idx_half == '0)
                    begin
                        state_next = S_PUSH_WR;
                    end
                    else
                    begin
                        mem_raddr = idx_quarter[ADDR_W-1:0];
                    end
                end
                else
                begin
                    count_next          = cnt_inc;
                    flags_next.accepted = 1'b1;
                    state_next          = S_OUT;
                end
            end

            S_PUSH_WR:
            begin
                mem_we              = 1'b1;
                count_next          = cnt_inc;
                flags_next.accepted = 1'b1;
                state_next          = S_OUT;
            end

            S_ROOT:
            begin
                root_next  = mem_rdata;
                mem_raddr  = cnt_dec[ADDR_W-1:0];
                cmp_a      = now_reg;
                cmp_a_base = rd_when;
                cmp_b      = DUE_LIMIT;
                if (cmd_reg == CMD_FIRE && !cmp_lt)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_LAST;
                end
            end

            S_LAST:
            begin
                last_next           = mem_rdata;
                last_idx_next       = cnt_dec;
                idx_next            = IDX_ONE;
                flags_next.accepted = 1'b1;
                flags_next.fired    = 1'b1;
                if (cnt_dec > CNT_ONE)
                begin
                    mem_raddr  = CNT_ONE[ADDR_W-1:0];
                    state_next = S_RD_A;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_RD_A:
            begin
                cand_next = mem_rdata;
                // Slot 1 has no sibling to weigh against.
                if (idx_reg > IDX_ONE)
                begin
                    mem_raddr  = idx_inc[ADDR_W-1:0];
                    state_next = S_RD_B;
                end
                else
                begin
                    state_next = S_SINK;
                end
            end

            S_RD_B:
            begin
                cmp_a      = rd_when;
                cmp_a_base = root_when;
                cmp_b      = cand_reg[DATA_W-1:HANDLE_BITS];
                cmp_b_base = root_when;
                if (cmp_lt)
                begin
                    cand_next = mem_rdata;
                    idx_next  = idx_inc;
                end
                state_next = S_SINK;
            end

            S_SINK:
            begin
                cmp_a      = last_reg[DATA_W-1:HANDLE_BITS];
                cmp_a_base = root_when;
                cmp_b      = cand_reg[DATA_W-1:HANDLE_BITS];
                cmp_b_base = root_when;
                mem_we     = 1'b1;
                mem_waddr  = idx_half[ADDR_W-1:0];
                if (cmp_lt)
                begin
                    mem_wdata  = last_reg;
                    count_next = last_idx_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    mem_wdata = cand_reg;
                    idx_next  = idx_dbl;
                    if (idx_dbl < {1'b0, last_idx_reg})
                    begin
                        mem_raddr  = idx_dbl[ADDR_W-1:0];
                        state_next = S_RD_A;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_FIN:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_half[ADDR_W-1:0];
                mem_wdata  = last_reg;
                count_next = last_idx_reg;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                // Hold the result until the output register is free.
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    out_flags_next = flags_reg;
                    out_hnd_next   = flags_reg.fired ? root_reg[HANDLE_BITS-1:0] : '0;
                    out_time_next  = flags_reg.fired ? root_when : '0;
                    out_cnt_next   = count_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            flags_reg     <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        now_reg       <= now_next;
        delay_reg     <= delay_next;
        hnd_reg       <= hnd_next;
        idx_reg       <= idx_next;
        last_idx_reg  <= last_idx_next;
        root_reg      <= root_next;
        last_reg      <= last_next;
        cand_reg      <= cand_next;
        out_flags_reg <= out_flags_next;
        out_hnd_reg   <= out_hnd_next;
        out_time_reg  <= out_time_next;
        out_cnt_reg   <= out_cnt_next;
    end

    assign cmd_ready    = (state_reg == S_IDLE);
    assign res_valid    = res_valid_reg;
    assign accepted     = out_flags_reg.accepted;
    assign overflow     = out_flags_reg.overflow;
    assign fired        = out_flags_reg.fired;
    assign fired_handle = out_hnd_reg;
    assign fired_time   = out_time_reg;
    assign entries      = out_cnt_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while previous one in work");

    a_overflow_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && overflow |-> !accepted && !fired && entries == CAP_CNT)
        else $error("overflow beat with inconsistent fields");

    a_no_fire_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !fired |-> fired_handle == '0 && fired_time == '0)
        else $error("removed-entry fields set without removal");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            count_reg == $past(count_reg) + CNT_ONE ||
            count_reg == $past(count_reg) - CNT_ONE)
        else $error("entry count moved by more than one");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_wrapping_time_priority_queue_top.sv -----
// Testbench for the timer heap queue: directed and random commands checked against a heap predictor.
`timescale 1ns / 100ps

module tb_wrapping_time_priority_queue_top;
    import twtq_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int TIME_BITS   = 16;
    localparam int HANDLE_BITS = 8;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int ITEMS       = 2000;
    localparam int DRAIN_CYCLES = 40;

    // Undefined command code; the block must treat it as a no-op.
    localparam cmd_t CMD_NONE = 2'd3;

    typedef logic [TIME_BITS-1:0]   tick_t;
    typedef logic [HANDLE_BITS-1:0] handle_t;
    typedef logic [COUNT_W-1:0]     count_t;

    localparam tick_t DUE_WINDOW = {TIME_BITS{1'b1}} >> 1;

    typedef struct packed {
        res_flags_t flags;
        handle_t    handle;
        tick_t      due;
        count_t     count;
    } outcome_t;

    class timer_heap_shadow;
        tick_t      slot_due[CAPACITY];
        handle_t    slot_handle[CAPACITY];
        int         count;
        outcome_t   pending_outcomes[$];
        int         errors;
        int         checked;
        int         removed;
        int         refused;

        function tick_t wrap_dist(tick_t t, tick_t base);
            return t - base;
        endfunction

        // Remove the root and sink the last entry from slot 1 down.
        function outcome_t take_root();
            outcome_t o;
            int       i;
            int       last;
            tick_t    base;
            o = '0;
            base = slot_due[0];
            o.flags.accepted = 1'b1;
            o.flags.fired = 1'b1;
            o.handle = slot_handle[0];
            o.due = slot_due[0];
            i = 1;
            last = count - 1;
            while (i < last)
            begin
                // slot 1 has a single child, so no sibling compare there
                if (i > 1 && wrap_dist(slot_due[i], base) > wrap_dist(slot_due[i + 1], base))
                    i++;
                if (wrap_dist(slot_due[last], base) < wrap_dist(slot_due[i], base))
                    break;
                slot_due[i / 2] = slot_due[i];
                slot_handle[i / 2] = slot_handle[i];
                i = 2 * i;
            end
            slot_due[i / 2] = slot_due[last];
            slot_handle[i / 2] = slot_handle[last];
            count = last;
            removed++;
            return o;
        endfunction

        function void note_command(cmd_t cmd, tick_t now, tick_t dly, handle_t hnd);
            outcome_t o;
            int       i;
            o = '0;
            case (cmd)
                CMD_PUSH:
                begin
                    if (count >= CAPACITY)
                    begin
                        o.flags.overflow = 1'b1;
                        refused++;
                    end
                    else
                    begin
                        i = count;
                        // a tie stays below the existing entry
                        while (i != 0 && dly < wrap_dist(slot_due[i / 2], now))
                        begin
                            slot_due[i] = slot_due[i / 2];
                            slot_handle[i] = slot_handle[i / 2];
                            i = i / 2;
                        end
                        slot_due[i] = now + dly;
                        slot_handle[i] = hnd;
                        count++;
                        o.flags.accepted = 1'b1;
                    end
                end
                CMD_FIRE:
                begin
                    if (count != 0 && wrap_dist(now, slot_due[0]) < DUE_WINDOW)
                        o = take_root();
                end
                CMD_POP:
                begin
                    if (count != 0)
                        o = take_root();
                end
                default:
                begin
                end
            endcase
            o.count = count_t'(count);
            pending_outcomes.push_back(o);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(res_flags_t f, handle_t h, tick_t t, count_t n);
            outcome_t want;
            if (pending_outcomes.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing outstanding, expected none, actual %0h",
                         $time, {f, h, t, n});
                return;
            end
            want = pending_outcomes.pop_front();
            checked++;
            compare("accepted", 32'(want.flags.accepted), 32'(f.accepted));
            compare("overflow", 32'(want.flags.overflow), 32'(f.overflow));
            compare("fired", 32'(want.flags.fired), 32'(f.fired));
            compare("fired_handle", 32'(want.handle), 32'(h));
            compare("fired_time", 32'(want.due), 32'(t));
            compare("entries", 32'(want.count), 32'(n));
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_ready;
    cmd_t       command;
    tick_t      time_now;
    tick_t      delay;
    handle_t    handle;
    logic       res_valid;
    logic       res_ready;
    logic       accepted;
    logic       overflow;
    logic       fired;
    handle_t    fired_handle;
    tick_t      fired_time;
    count_t     entries;

    int send_idle_pct;
    int recv_idle_pct;
    int issued;
    int pushes;

    timer_heap_shadow tracker = new();

    wrapping_time_priority_queue_top #(
        .CAPACITY    (CAPACITY),
        .TIME_BITS   (TIME_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .command      (command),
        .time_now     (time_now),
        .delay        (delay),
        .handle       (handle),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .accepted     (accepted),
        .overflow     (overflow),
        .fired        (fired),
        .fired_handle (fired_handle),
        .fired_time   (fired_time),
        .entries      (entries)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver: stall at random, check every accepted result beat.
    always @(negedge clk)
    begin
        res_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            tracker.check_result({accepted, overflow, fired}, fired_handle, fired_time, entries);
    end

    // Hold the beat until accepted, then predict its result.
    task automatic send_beat(cmd_t c, tick_t now, tick_t dly, handle_t hnd);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd_valid = 1'b1;
        command = c;
        time_now = now;
        delay = dly;
        handle = hnd;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        tracker.note_command(c, now, dly, hnd);
        if (c != CMD_NONE)
            issued++;
        if (c == CMD_PUSH)
            pushes++;
    endtask

    task automatic run_random();
        tick_t   clock_now;
        tick_t   now;
        tick_t   dly;
        cmd_t    c;
        bit      filling;
        int      roll;
        clock_now = tick_t'($urandom);
        filling = 1'b1;
        while (issued < ITEMS)
        begin
            if (issued < ITEMS / 3)
            begin
                send_idle_pct = 24;
                recv_idle_pct = 69;
            end
            else if (issued < 2 * ITEMS / 3)
            begin
                send_idle_pct = 69;
                recv_idle_pct = 24;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(39) == 0)
                filling = !filling;
            roll = $urandom_range(99);
            if (roll < 2)
                c = CMD_NONE;
            else if (filling)
                c = (roll < 72) ? CMD_PUSH : (roll < 90) ? CMD_FIRE : CMD_POP;
            else
                c = (roll < 27) ? CMD_PUSH : (roll < 75) ? CMD_FIRE : CMD_POP;
            // advance the wall clock so queued timers come due
            clock_now = clock_now + tick_t'($urandom_range(400));
            now = ($urandom_range(9) == 0) ? tick_t'($urandom) : clock_now;
            roll = $urandom_range(99);
            if (roll < 80)
                dly = tick_t'($urandom_range(2000));
            else if (roll < 90)
                dly = tick_t'($urandom);
            else
            begin
                case ($urandom_range(3))
                    0: dly = '0;
                    1: dly = '1;
                    2: dly = DUE_WINDOW;
                    default: dly = DUE_WINDOW + 1'b1;
                endcase
            end
            send_beat(c, now, dly, handle_t'($urandom_range(255)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        command = CMD_PUSH;
        time_now = '0;
        delay = '0;
        handle = '0;
        res_ready = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 69;
        issued = 0;
        pushes = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty heap: nothing to remove, unused code is a no-op
        send_beat(CMD_POP, 16'h0000, 16'h0000, 8'h00);
        send_beat(CMD_FIRE, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_beat(CMD_NONE, 16'h1234, 16'h5678, 8'h9A);
        // field extremes, wrap on due time, ties on due time 0
        send_beat(CMD_PUSH, 16'h0000, 16'h0000, 8'h00);
        send_beat(CMD_PUSH, 16'h0000, 16'hFFFF, 8'hFF);
        send_beat(CMD_PUSH, 16'hFFFF, 16'h0001, 8'h5A);
        send_beat(CMD_PUSH, 16'h0064, 16'h0000, 8'hA5);
        send_beat(CMD_PUSH, 16'hFFFF, 16'hFFFF, 8'h01);
        send_beat(CMD_PUSH, 16'h0000, DUE_WINDOW, 8'h02);
        send_beat(CMD_PUSH, 16'h0000, DUE_WINDOW + 1'b1, 8'h03);
        send_beat(CMD_FIRE, 16'h0000, 16'h0000, 8'h00);
        send_beat(CMD_NONE, 16'hFFFF, 16'hFFFF, 8'hFF);
        // drain everything, then one pop past empty
        repeat (7) send_beat(CMD_POP, 16'h0000, 16'h0000, 8'h00);
        // due window edge: DUE_WINDOW ticks past due does not fire, one tick less fires
        send_beat(CMD_PUSH, 16'h03E8, 16'h0000, 8'h07);
        send_beat(CMD_FIRE, 16'h03E8 + DUE_WINDOW, 16'h0000, 8'h00);
        send_beat(CMD_FIRE, 16'h03E8 + DUE_WINDOW - 1'b1, 16'h0000, 8'h00);

        run_random();

        @(negedge clk);
        cmd_valid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d commands (%0d pushes), %0d results checked, %0d errors",
                 issued, pushes, tracker.checked, tracker.errors);
        $display("heap removals: %0d, pushes refused on a full heap: %0d",
                 tracker.removed, tracker.refused);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("run timed out with %0d results outstanding", tracker.pending());
        $display("status: fail");
        $finish;
    end

endmodule
